[hw/rtl/i2c_bus_clear_sequencer_macros.svh]
// Assertion macros shared by the bus-clear sequencer RTL.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef I2C_BUS_CLEAR_SEQUENCER_MACROS_SVH
`define I2C_BUS_CLEAR_SEQUENCER_MACROS_SVH

// Property holds at every clock edge outside reset.
`define BCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent implies consequent on the following edge.
`define BCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/i2cbc_pkg.sv]
// Package for the I2C bus-clear sequencer: transaction types, register map,
// phase encoding and reset values. No dependencies.
package i2cbc_pkg;

  localparam int unsigned TimerBits   = 14;
  localparam int unsigned AttemptBits = 16;
  localparam int unsigned AddrW       = 5;
  localparam int unsigned DataW       = 32;

  localparam logic [7:0]  SettleRst   = 8'd10;
  localparam logic [7:0]  HalfRst     = 8'd5;
  localparam logic [13:0] InitWaitRst = 14'd10000;
  localparam logic [13:0] PulseWaitRst = 14'd1000;
  localparam logic [3:0]  MaxPulseRst = 4'd9;

  typedef enum logic [2:0] {
    REG_SETTLE     = 3'd0,
    REG_HALF       = 3'd1,
    REG_INIT_WAIT  = 3'd2,
    REG_PULSE_WAIT = 3'd3,
    REG_MAX_PULSES = 3'd4
  } reg_idx_e;

  typedef enum logic [10:0] {
    PH_IDLE       = 11'b000_0000_0001,
    PH_SETTLE     = 11'b000_0000_0010,
    PH_WAIT_INIT  = 11'b000_0000_0100,
    PH_PULSE_LOW  = 11'b000_0000_1000,
    PH_PULSE_WAIT = 11'b000_0001_0000,
    PH_PULSE_HOLD = 11'b000_0010_0000,
    PH_STOP_SDA   = 11'b000_0100_0000,
    PH_STOP_WAIT  = 11'b000_1000_0000,
    PH_STOP_HOLD  = 11'b001_0000_0000,
    PH_STOP_TAIL  = 11'b010_0000_0000,
    PH_FINISH     = 11'b100_0000_0000
  } phase_e;

  typedef struct packed {
    logic kind;
    logic sda_level;
    logic scl_level;
  } in_item_t;

  typedef struct packed {
    logic        scl_drive_low;
    logic        sda_drive_low;
    logic        busy_res;
    logic        done_res;
    logic [3:0]  pulse_count;
    logic        final_sda_high;
    logic        final_scl_high;
    logic        bus_free;
    logic        start_sda_low;
    logic        start_scl_low;
    logic [15:0] attempt_count;
  } out_item_t;

endpackage

[hw/rtl/i2c_bus_clear_sequencer.sv]
// I2C bus-clear sequencer: one input transaction is one time tick.
// The result of a tick is registered at the edge that accepts the tick.
// Throughput: one transaction per cycle; the input stalls only while a second
// result waits behind a stalled head entry.
// Reset: asynchronous, active low; idle, lines released, counters zero, config at defaults.
// Depends on i2cbc_pkg and i2c_bus_clear_sequencer_macros.svh.
`include "i2c_bus_clear_sequencer_macros.svh"

module i2c_bus_clear_sequencer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  i2cbc_pkg::in_item_t        in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output i2cbc_pkg::out_item_t       out_data_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [i2cbc_pkg::AddrW-1:0] paddr,
  input  logic [i2cbc_pkg::DataW-1:0] pwdata,
  output logic [i2cbc_pkg::DataW-1:0] prdata,
  output logic                       pready
);
  import i2cbc_pkg::*;

  // configuration
  logic [7:0]  settle_q, half_q;
  logic [13:0] init_wait_q, pulse_wait_q;
  logic [3:0]  max_pulses_q;
  reg_idx_e    reg_idx;
  logic        cfg_wr;

  // sequencer state
  phase_e                 phase_q, phase_d;
  logic [TimerBits-1:0]   timer_q, timer_d;
  logic [3:0]             pulses_q, pulses_d;
  logic                   scl_pull_q, scl_pull_d;
  logic                   sda_pull_q, sda_pull_d;
  logic                   last_sda_q, last_sda_d;
  logic                   last_scl_q, last_scl_d;
  logic                   first_sda_low_q, first_sda_low_d;
  logic                   first_scl_low_q, first_scl_low_d;
  logic [AttemptBits-1:0] attempts_q, attempts_d;
  logic                   done;

  logic                   timer_exp;
  logic [TimerBits-1:0]   timer_dec;
  logic [TimerBits-1:0]   ld_settle, ld_half, ld_init, ld_pulse;
  logic                   pulse_again;

  // output buffer
  logic      in_accept, out_pop;
  out_item_t res;
  out_item_t out_q, skid_q;
  logic      out_valid_q, skid_valid_q;

  // ---------------------------------------------------------------- APB
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_SETTLE:     prdata = DataW'(settle_q);
      REG_HALF:       prdata = DataW'(half_q);
      REG_INIT_WAIT:  prdata = DataW'(init_wait_q);
      REG_PULSE_WAIT: prdata = DataW'(pulse_wait_q);
      REG_MAX_PULSES: prdata = DataW'(max_pulses_q);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q     <= SettleRst;
      half_q       <= HalfRst;
      init_wait_q  <= InitWaitRst;
      pulse_wait_q <= PulseWaitRst;
      max_pulses_q <= MaxPulseRst;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_SETTLE:     settle_q     <= pwdata[7:0];
        REG_HALF:       half_q       <= pwdata[7:0];
        REG_INIT_WAIT:  init_wait_q  <= pwdata[13:0];
        REG_PULSE_WAIT: pulse_wait_q <= pwdata[13:0];
        REG_MAX_PULSES: max_pulses_q <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- sequencer
  assign timer_exp = (timer_q <= TimerBits'(1));
  assign timer_dec = timer_q - TimerBits'(1);
  assign ld_settle = TimerBits'(settle_q);
  assign ld_half   = TimerBits'(half_q);
  assign ld_init   = TimerBits'(init_wait_q);
  assign ld_pulse  = TimerBits'(pulse_wait_q);

  always_comb begin
    phase_d         = phase_q;
    timer_d         = timer_q;
    pulses_d        = pulses_q;
    scl_pull_d      = scl_pull_q;
    sda_pull_d      = sda_pull_q;
    last_sda_d      = last_sda_q;
    last_scl_d      = last_scl_q;
    first_sda_low_d = first_sda_low_q;
    first_scl_low_d = first_scl_low_q;
    attempts_d      = attempts_q;
    done            = 1'b0;
    pulse_again     = 1'b0;

    case (phase_q)
      PH_IDLE: begin
        if (in_data_i.kind) begin
          if (attempts_q != '1) attempts_d = attempts_q + AttemptBits'(1);
          pulses_d   = '0;
          scl_pull_d = 1'b0;
          sda_pull_d = 1'b0;
          timer_d    = ld_settle;
          phase_d    = PH_SETTLE;
        end
      end
      PH_SETTLE: begin
        timer_d = timer_exp ? '0 : timer_dec;
        if (timer_exp) begin
          first_sda_low_d = !in_data_i.sda_level;
          first_scl_low_d = !in_data_i.scl_level;
          timer_d         = ld_init;
          phase_d         = PH_WAIT_INIT;
        end
      end
      PH_WAIT_INIT: begin
        if (in_data_i.scl_level) begin
          pulse_again = !in_data_i.sda_level && (pulses_q < max_pulses_q);
          if (pulse_again) begin
            scl_pull_d = 1'b1;
            timer_d    = ld_half;
            phase_d    = PH_PULSE_LOW;
          end else begin
            sda_pull_d = 1'b1;
            timer_d    = ld_half;
            phase_d    = PH_STOP_SDA;
          end
        end else if (timer_exp) begin
          // SCL never came up: report failure right away
          last_sda_d = in_data_i.sda_level;
          last_scl_d = 1'b0;
          scl_pull_d = 1'b0;
          sda_pull_d = 1'b0;
          timer_d    = '0;
          phase_d    = PH_IDLE;
          done       = 1'b1;
        end else begin
          timer_d = timer_dec;
        end
      end
      PH_PULSE_LOW: begin
        timer_d = timer_exp ? '0 : timer_dec;
        if (timer_exp) begin
          scl_pull_d = 1'b0;
          timer_d    = ld_pulse;
          phase_d    = PH_PULSE_WAIT;
        end
      end
      PH_PULSE_WAIT: begin
        if (in_data_i.scl_level) begin
          timer_d = ld_half;
          phase_d = PH_PULSE_HOLD;
        end else if (timer_exp) begin
          // stretched too long: skip to STOP without counting this pulse
          sda_pull_d = 1'b1;
          timer_d    = ld_half;
          phase_d    = PH_STOP_SDA;
        end else begin
          timer_d = timer_dec;
        end
      end
      PH_PULSE_HOLD: begin
        timer_d = timer_exp ? '0 : timer_dec;
        if (timer_exp) begin
          pulses_d    = pulses_q + 4'd1;
          pulse_again = !in_data_i.sda_level && (pulses_d < max_pulses_q);
          timer_d     = ld_half;
          if (pulse_again) begin
            scl_pull_d = 1'b1;
            phase_d    = PH_PULSE_LOW;
          end else begin
            sda_pull_d = 1'b1;
            phase_d    = PH_STOP_SDA;
          end
        end
      end
      PH_STOP_SDA: begin
        timer_d = timer_exp ? '0 : timer_dec;
        if (timer_exp) begin
          scl_pull_d = 1'b0;
          timer_d    = ld_pulse;
          phase_d    = PH_STOP_WAIT;
        end
      end
      PH_STOP_WAIT: begin
        if (in_data_i.scl_level) begin
          timer_d = ld_half;
          phase_d = PH_STOP_HOLD;
        end else if (timer_exp) begin
          timer_d    = '0;
          sda_pull_d = 1'b0;
          phase_d    = PH_FINISH;
        end else begin
          timer_d = timer_dec;
        end
      end
      PH_STOP_HOLD: begin
        timer_d = timer_exp ? '0 : timer_dec;
        if (timer_exp) begin
          sda_pull_d = 1'b0;
          timer_d    = ld_half;
          phase_d    = PH_STOP_TAIL;
        end
      end
      PH_STOP_TAIL: begin
        timer_d = timer_exp ? '0 : timer_dec;
        if (timer_exp) begin
          last_sda_d = in_data_i.sda_level;
          last_scl_d = in_data_i.scl_level;
          scl_pull_d = 1'b0;
          sda_pull_d = 1'b0;
          timer_d    = '0;
          phase_d    = PH_IDLE;
          done       = 1'b1;
        end
      end
      default: begin
        // finish step after a stop timeout
        last_sda_d = in_data_i.sda_level;
        last_scl_d = in_data_i.scl_level;
        scl_pull_d = 1'b0;
        sda_pull_d = 1'b0;
        timer_d    = '0;
        phase_d    = PH_IDLE;
        done       = 1'b1;
      end
    endcase
  end

  always_comb begin
    res.scl_drive_low  = scl_pull_d;
    res.sda_drive_low  = sda_pull_d;
    res.busy_res       = (phase_d != PH_IDLE);
    res.done_res       = done;
    res.pulse_count    = pulses_d;
    res.final_sda_high = last_sda_d;
    res.final_scl_high = last_scl_d;
    res.bus_free       = last_sda_d && last_scl_d;
    res.start_sda_low  = first_sda_low_d;
    res.start_scl_low  = first_scl_low_d;
    res.attempt_count  = 16'(attempts_d);
  end

  assign in_accept = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_IDLE;
      timer_q         <= '0;
      pulses_q        <= '0;
      scl_pull_q      <= 1'b0;
      sda_pull_q      <= 1'b0;
      last_sda_q      <= 1'b0;
      last_scl_q      <= 1'b0;
      first_sda_low_q <= 1'b0;
      first_scl_low_q <= 1'b0;
      attempts_q      <= '0;
    end else if (in_accept) begin
      phase_q         <= phase_d;
      timer_q         <= timer_d;
      pulses_q        <= pulses_d;
      scl_pull_q      <= scl_pull_d;
      sda_pull_q      <= sda_pull_d;
      last_sda_q      <= last_sda_d;
      last_scl_q      <= last_scl_d;
      first_sda_low_q <= first_sda_low_d;
      first_scl_low_q <= first_scl_low_d;
      attempts_q      <= attempts_d;
    end
  end

  // ---------------------------------------------------------------- output buffer
  // Two entries: the skid entry fills only when the head is held by the sink.
  assign out_pop     = out_valid_q && !out_stall_i;
  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_pop) skid_valid_q <= 1'b0;
    end else if (in_accept) begin
      if (out_valid_q && !out_pop) skid_valid_q <= 1'b1;
      else                         out_valid_q  <= 1'b1;
    end else if (out_pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_pop) out_q <= skid_q;
    end else if (in_accept) begin
      if (out_valid_q && !out_pop) skid_q <= res;
      else                         out_q  <= res;
    end
  end

  // ---------------------------------------------------------------- checks
  `BCS_ASSERT(a_scl_pull_only_low, !scl_pull_q || (phase_q == PH_PULSE_LOW), "SCL pulled")
  `BCS_ASSERT(a_idle_released, (phase_q != PH_IDLE) || (!scl_pull_q && !sda_pull_q), "idle pull")
  `BCS_ASSERT(a_skid_needs_head, !skid_valid_q || out_valid_q, "skid entry without head entry")
  `BCS_ASSERT(a_done_not_busy, !out_valid_q || !out_q.done_res || !out_q.busy_res, "done and busy")
  `BCS_ASSERT_NEXT(a_attempts_mono, 1'b1, attempts_q >= $past(attempts_q), "attempts fell")

endmodule
